[rtl/mrdf_pkg.sv]
// Shared widths, codes and reset values of the mesh relay duplicate filter.
package mrdf_pkg;

    localparam int ADDR_W      = 14;
    localparam int ID_W        = 7;
    localparam int TTL_W       = 4;
    localparam int KEY_W       = ADDR_W + ID_W;
    localparam int ACTION_W    = 3;
    localparam int CFG_INDEX_W = 8;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 8;

    localparam int HISTORY_DEPTH_DEF = 20;

    localparam logic [ADDR_W-1:0] OWN_ADDRESS_RST     = 14'd1100;
    localparam logic [ADDR_W-1:0] GROUP_ADDRESS_A_RST = 14'd1003;
    localparam logic [ADDR_W-1:0] GROUP_ADDRESS_B_RST = 14'd1002;
    localparam logic [ADDR_W-1:0] GROUP_ADDRESS_C_RST = 14'd1001;

    localparam logic [CFG_INDEX_W-1:0] REG_OWN_ADDRESS     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GROUP_ADDRESS_A = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GROUP_ADDRESS_B = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GROUP_ADDRESS_C = 8'd3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PROCESS   = 3'd0,
        ACT_LOCAL_DUP = 3'd1,
        ACT_FORWARD   = 3'd2,
        ACT_RELAY_DUP = 3'd3,
        ACT_EXPIRED   = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

[rtl/mrdf_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module mrdf_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/mesh_relay_duplicate_filter.sv]
// Top level of the mesh relay duplicate filter: header decode, history scan and result.
//
// Usage: each word on the s_ channel is one received packet header. Packets for
// this node or one of its three group addresses are checked against the local
// history of (source, id) keys; all others against the relay history. One
// result word per header leaves on the m_ channel: the action and, when
// forwarding, the lowered TTL.
// The four address registers are written over the cfg_ channel, which is
// always ready; writes to an index beyond the list are ignored.
// Both histories share one RAM and are scanned one entry per cycle through its
// single read port; a new key is compared against every entry of its history,
// and the scan stops at the entry where the key is found. The result is then
// loaded into the output register from ST_FINISH.
// A new header is accepted while a result still waits in the output register;
// if the receiver stalls, the finished result of the following header waits
// until the output register is taken, and no further header is accepted.
// Reset clears the valid bits and pointers of both histories at once and loads
// the address registers with their defaults; no clearing pass is needed.
module mesh_relay_duplicate_filter #(
    parameter int HISTORY_DEPTH = mrdf_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: source_address[13:0], dest_address[27:14], packet_id[34:28],
    // hop_ttl[38:35], zero[39]
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mrdf_pkg::S_TDATA_W-1:0]   s_tdata,
    // m_tdata: action[2:0], forward_ttl[6:3], zero[7]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mrdf_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mrdf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mrdf_pkg::ADDR_W-1:0]      cfg_data
);

    import mrdf_pkg::*;

    localparam int IDX_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int RAM_DEPTH = 2 * HISTORY_DEPTH;
    localparam int RAM_AW   = $clog2(RAM_DEPTH);
    localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(HISTORY_DEPTH - 1);
    localparam logic [RAM_AW-1:0] RELAY_BASE = RAM_AW'(HISTORY_DEPTH);
    localparam int PAD_W = M_TDATA_W - ACTION_W - TTL_W;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] own_address_reg, own_address_next;
    logic [ADDR_W-1:0] group_a_reg, group_a_next;
    logic [ADDR_W-1:0] group_b_reg, group_b_next;
    logic [ADDR_W-1:0] group_c_reg, group_c_next;

    logic [KEY_W-1:0] key_reg, key_next;
    logic             local_sel_reg, local_sel_next;
    logic [TTL_W-1:0] ttl_reg, ttl_next;

    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             rd_busy_reg, rd_busy_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;

    logic [HISTORY_DEPTH-1:0] local_valid_reg, local_valid_next;
    logic [HISTORY_DEPTH-1:0] relay_valid_reg, relay_valid_next;
    logic [IDX_W-1:0]         local_ptr_reg, local_ptr_next;
    logic [IDX_W-1:0]         relay_ptr_reg, relay_ptr_next;

    action_t          res_action_reg, res_action_next;
    logic [TTL_W-1:0] res_ttl_reg, res_ttl_next;

    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic [ADDR_W-1:0] in_src, in_dst;
    logic [ID_W-1:0]   in_pid;
    logic [TTL_W-1:0]  in_ttl;
    logic              dst_match;
    logic              in_fire, m_fire;
    logic              entry_valid, hit, scan_end;
    logic [IDX_W-1:0]  cur_ptr, ptr_inc;
    logic [RAM_AW-1:0] base_addr;

    logic              rd_en, wr_en;
    logic [RAM_AW-1:0] rd_addr, wr_addr;
    logic [KEY_W-1:0]  rd_data;

    assign in_src = s_tdata[ADDR_W-1:0];
    assign in_dst = s_tdata[2*ADDR_W-1:ADDR_W];
    assign in_pid = s_tdata[2*ADDR_W+ID_W-1:2*ADDR_W];
    assign in_ttl = s_tdata[2*ADDR_W+ID_W+TTL_W-1:2*ADDR_W+ID_W];

    assign dst_match = (in_dst == own_address_reg) || (in_dst == group_a_reg) ||
                       (in_dst == group_b_reg) || (in_dst == group_c_reg);

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign m_fire    = m_valid_reg && m_tready;

    assign entry_valid = local_sel_reg ? local_valid_reg[cmp_idx_reg]
                                       : relay_valid_reg[cmp_idx_reg];
    assign hit      = cmp_vld_reg && entry_valid && (rd_data == key_reg);
    assign scan_end = cmp_vld_reg && (hit || (cmp_idx_reg == LAST_IDX));

    assign cur_ptr   = local_sel_reg ? local_ptr_reg : relay_ptr_reg;
    assign ptr_inc   = (cur_ptr == LAST_IDX) ? '0 : cur_ptr + 1'b1;
    assign base_addr = local_sel_reg ? '0 : RELAY_BASE;

    // Writes only happen on the last compare of an item, and the next item's
    // first read comes only after ST_FINISH and ST_IDLE, so no forwarding is needed.
    assign rd_en   = (state_reg == ST_SCAN) && rd_busy_reg;
    assign rd_addr = base_addr + RAM_AW'(rd_idx_reg);
    assign wr_en   = (state_reg == ST_SCAN) && scan_end && !hit;
    assign wr_addr = base_addr + RAM_AW'(cur_ptr);

    mrdf_ram #(
        .WIDTH  (KEY_W),
        .DEPTH  (RAM_DEPTH),
        .ADDR_W (RAM_AW)
    ) u_history_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (key_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next       = state_reg;
        own_address_next = own_address_reg;
        group_a_next     = group_a_reg;
        group_b_next     = group_b_reg;
        group_c_next     = group_c_reg;
        key_next         = key_reg;
        local_sel_next   = local_sel_reg;
        ttl_next         = ttl_reg;
        rd_idx_next      = rd_idx_reg;
        rd_busy_next     = rd_busy_reg;
        cmp_vld_next     = cmp_vld_reg;
        cmp_idx_next     = cmp_idx_reg;
        local_valid_next = local_valid_reg;
        relay_valid_next = relay_valid_reg;
        local_ptr_next   = local_ptr_reg;
        relay_ptr_next   = relay_ptr_reg;
        res_action_next  = res_action_reg;
        res_ttl_next     = res_ttl_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_OWN_ADDRESS:     own_address_next = cfg_data;
                REG_GROUP_ADDRESS_A: group_a_next     = cfg_data;
                REG_GROUP_ADDRESS_B: group_b_next     = cfg_data;
                REG_GROUP_ADDRESS_C: group_c_next     = cfg_data;
                default: ;
            endcase
        end

        if (m_fire) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    key_next       = {in_src, in_pid};
                    local_sel_next = dst_match;
                    ttl_next       = in_ttl;
                    rd_idx_next    = '0;
                    rd_busy_next   = 1'b1;
                    cmp_vld_next   = 1'b0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmp_vld_next = rd_en;
                cmp_idx_next = rd_idx_reg;
                if (rd_en) begin
                    if (rd_idx_reg == LAST_IDX) begin
                        rd_busy_next = 1'b0;
                    end else begin
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                end
                if (scan_end) begin
                    rd_busy_next = 1'b0;
                    cmp_vld_next = 1'b0;
                    state_next   = ST_FINISH;
                    res_ttl_next = '0;
                    if (hit) begin
                        res_action_next = local_sel_reg ? ACT_LOCAL_DUP : ACT_RELAY_DUP;
                    end else begin
                        if (local_sel_reg) begin
                            local_valid_next[cur_ptr] = 1'b1;
                            local_ptr_next            = ptr_inc;
                            res_action_next           = ACT_PROCESS;
                        end else begin
                            relay_valid_next[cur_ptr] = 1'b1;
                            relay_ptr_next            = ptr_inc;
                            if (ttl_reg != '0) begin
                                res_action_next = ACT_FORWARD;
                                res_ttl_next    = ttl_reg - 1'b1;
                            end else begin
                                res_action_next = ACT_EXPIRED;
                            end
                        end
                    end
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{PAD_W{1'b0}}, res_ttl_reg, res_action_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            own_address_reg <= OWN_ADDRESS_RST;
            group_a_reg     <= GROUP_ADDRESS_A_RST;
            group_b_reg     <= GROUP_ADDRESS_B_RST;
            group_c_reg     <= GROUP_ADDRESS_C_RST;
            rd_busy_reg     <= 1'b0;
            cmp_vld_reg     <= 1'b0;
            local_valid_reg <= '0;
            relay_valid_reg <= '0;
            local_ptr_reg   <= '0;
            relay_ptr_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            own_address_reg <= own_address_next;
            group_a_reg     <= group_a_next;
            group_b_reg     <= group_b_next;
            group_c_reg     <= group_c_next;
            rd_busy_reg     <= rd_busy_next;
            cmp_vld_reg     <= cmp_vld_next;
            local_valid_reg <= local_valid_next;
            relay_valid_reg <= relay_valid_next;
            local_ptr_reg   <= local_ptr_next;
            relay_ptr_reg   <= relay_ptr_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg        <= key_next;
        local_sel_reg  <= local_sel_next;
        ttl_reg        <= ttl_next;
        rd_idx_reg     <= rd_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        res_action_reg <= res_action_next;
        res_ttl_reg    <= res_ttl_next;
        m_data_reg     <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[rtl/mrdf_checker.sv]
// Port-level checks of the mesh relay duplicate filter and their binding.
module mrdf_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mrdf_pkg::M_TDATA_W-1:0] m_tdata
);

    import mrdf_pkg::*;

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed or dropped while stalled");

    // Only a forwarded packet carries a nonzero TTL.
    a_ttl_only_forward: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[ACTION_W-1:0] != ACT_FORWARD)
        |-> (m_tdata[ACTION_W+TTL_W-1:ACTION_W] == '0))
        else $error("forward_ttl set on a result that is not a forward");

    // A header is followed by a history scan, so the input closes for a while.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("input accepted again during a history scan");

    // Reset leaves no result word pending.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

endmodule

bind mesh_relay_duplicate_filter mrdf_checker u_mrdf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/sv/tb_mesh_relay_duplicate_filter.sv]
// Self-checking testbench of the mesh relay duplicate filter: directed and random headers.
module tb_mesh_relay_duplicate_filter;
    import mrdf_pkg::*;

    localparam int DEPTH          = HISTORY_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = DEPTH + 8;
    localparam int LOCAL_RING     = 0;
    localparam int RELAY_RING     = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_FIRST = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LAST  = 8'd255;

    typedef struct {
        logic [ADDR_W-1:0] source;
        logic [ADDR_W-1:0] dest;
        logic [ID_W-1:0]   pid;
        logic [TTL_W-1:0]  ttl;
    } header_t;

    typedef struct {
        action_t          action;
        logic [TTL_W-1:0] fwd_ttl;
    } verdict_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]      cfg_data  = '0;

    // Shadow copy of the address registers and both key histories.
    logic [ADDR_W-1:0] addr_regs [0:3];
    logic [KEY_W-1:0]  seen_keys [0:1][0:DEPTH-1];
    bit                seen_valid [0:1][0:DEPTH-1];
    int unsigned       ring_ptr [0:1];

    verdict_t pending_verdicts[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int rx_hold_left   = 0;
    int err_count      = 0;
    int quiet_cycles   = 0;

    mesh_relay_duplicate_filter #(
        .HISTORY_DEPTH(DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #6 aclk = ~aclk;

    function automatic void clear_model();
        addr_regs[0] = OWN_ADDRESS_RST;
        addr_regs[1] = GROUP_ADDRESS_A_RST;
        addr_regs[2] = GROUP_ADDRESS_B_RST;
        addr_regs[3] = GROUP_ADDRESS_C_RST;
        for (int r = 0; r < 2; r++) begin
            ring_ptr[r] = 0;
            for (int i = 0; i < DEPTH; i++) begin
                seen_valid[r][i] = 1'b0;
                seen_keys[r][i]  = '0;
            end
        end
    endfunction

    // Returns 1 for a known key; a new key is written at the ring pointer.
    function automatic bit check_and_record(input int ring, input logic [KEY_W-1:0] key);
        for (int i = 0; i < DEPTH; i++) begin
            if (seen_valid[ring][i] && seen_keys[ring][i] == key) return 1'b1;
        end
        seen_keys[ring][ring_ptr[ring]]  = key;
        seen_valid[ring][ring_ptr[ring]] = 1'b1;
        ring_ptr[ring] = (ring_ptr[ring] == DEPTH - 1) ? 0 : ring_ptr[ring] + 1;
        return 1'b0;
    endfunction

    function automatic verdict_t classify_header(input header_t h);
        verdict_t         v;
        logic [KEY_W-1:0] key;
        key       = {h.source, h.pid};
        v.fwd_ttl = '0;
        if (h.dest == addr_regs[0] || h.dest == addr_regs[1] ||
            h.dest == addr_regs[2] || h.dest == addr_regs[3]) begin
            v.action = check_and_record(LOCAL_RING, key) ? ACT_LOCAL_DUP : ACT_PROCESS;
        end else if (check_and_record(RELAY_RING, key)) begin
            v.action = ACT_RELAY_DUP;
        end else if (h.ttl != '0) begin
            v.action  = ACT_FORWARD;
            v.fwd_ttl = h.ttl - 1'b1;
        end else begin
            v.action = ACT_EXPIRED;
        end
        return v;
    endfunction

    function automatic header_t hdr(input int unsigned source, dest, pid, ttl);
        header_t h;
        h.source = ADDR_W'(source);
        h.dest   = ADDR_W'(dest);
        h.pid    = ID_W'(pid);
        h.ttl    = TTL_W'(ttl);
        return h;
    endfunction

    // Small source and id pools make repeats and ring evictions common.
    function automatic header_t random_header();
        header_t     h;
        int unsigned pick;
        h.source = ($urandom_range(99) < 70) ? ADDR_W'(1000 + $urandom_range(5))
                                             : ADDR_W'($urandom);
        h.pid    = ($urandom_range(99) < 70) ? ID_W'($urandom_range(7)) : ID_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 45) begin
            h.dest = addr_regs[$urandom_range(3)];
        end else if (pick < 85) begin
            h.dest = ADDR_W'(2000 + $urandom_range(3));
        end else begin
            h.dest = ADDR_W'($urandom);
        end
        h.ttl = ($urandom_range(99) < 15) ? '0 : TTL_W'($urandom);
        return h;
    endfunction

    function automatic logic [ADDR_W-1:0] random_address();
        if ($urandom_range(3) == 0) return ADDR_W'(2000 + $urandom_range(3));
        return ADDR_W'($urandom_range(9999));
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= 50) $display("ERROR at %0t: %s", $time, what);
    endtask

    task automatic send_header(input header_t h);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, h.ttl, h.pid, h.dest, h.source};
        do @(posedge aclk); while (!s_tready);
        pending_verdicts.push_back(classify_header(h));
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_verdicts.size() != 0) @(posedge aclk);
    endtask

    task automatic set_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [ADDR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx <= REG_GROUP_ADDRESS_C) addr_regs[idx[1:0]] = value;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Result checking and receiver stalls.
    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch($sformatf("result word 0x%02h with nothing outstanding", m_tdata));
            end else begin
                want = pending_verdicts.pop_front();
                if (m_tdata[ACTION_W-1:0] !== want.action)
                    report_mismatch($sformatf("action %0d, predicted %0d",
                                              m_tdata[ACTION_W-1:0], want.action));
                if (m_tdata[ACTION_W +: TTL_W] !== want.fwd_ttl)
                    report_mismatch($sformatf("forward_ttl %0d, predicted %0d",
                                              m_tdata[ACTION_W +: TTL_W], want.fwd_ttl));
            end
        end
        if (rx_hold_left > 0) begin
            m_tready <= 1'b0;
            rx_hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic test_default_addresses();
        send_header(hdr(1, 1100, 1, 3));
        send_header(hdr(1, 1100, 1, 3));
        send_header(hdr(1, 1003, 1, 7));
        send_header(hdr(2, 1002, 0, 0));
        send_header(hdr(3, 1001, 127, 15));
        // The relay history is separate, so the same key is new there.
        send_header(hdr(1, 2000, 1, 3));
        send_header(hdr(1, 2000, 1, 3));
        send_header(hdr(4, 2000, 5, 0));
        // An expired key was still recorded.
        send_header(hdr(4, 3000, 5, 9));
        send_header(hdr(5, 0, 0, 15));
        send_header(hdr(16383, 16383, 127, 9));
        send_header(hdr(0, 9999, 0, 1));
        send_header(hdr(0, 1100, 0, 1));
        send_header(hdr(16383, 1100, 127, 0));
        send_header(hdr(9999, 12000, 99, 10));
        send_header(hdr(14'h2AAA, 14'h1555, 7'h55, 4'hA));
        send_header(hdr(14'h1555, 14'h2AAA, 7'h2A, 4'h5));
        send_header(hdr(16383, 1100, 127, 4));
        send_header(hdr(1, 1101, 1, 1));
        wait_for_results();
    endtask

    task automatic test_address_registers();
        set_register(REG_OWN_ADDRESS, 14'd0);
        set_register(REG_GROUP_ADDRESS_A, 14'd9999);
        set_register(REG_GROUP_ADDRESS_B, 14'd16383);
        set_register(REG_GROUP_ADDRESS_C, 14'd5000);
        // Writes beyond the register list must leave everything unchanged.
        set_register(REG_UNUSED_FIRST, 14'd1100);
        set_register(REG_UNUSED_LAST, 14'd1003);
        send_header(hdr(10, 0, 10, 2));
        send_header(hdr(10, 9999, 10, 2));
        send_header(hdr(11, 16383, 3, 3));
        send_header(hdr(12, 5000, 4, 4));
        send_header(hdr(13, 1100, 5, 5));
        send_header(hdr(14, 1003, 6, 0));
        wait_for_results();
        set_register(REG_OWN_ADDRESS, 14'd9999);
        set_register(REG_GROUP_ADDRESS_A, 14'd9999);
        set_register(REG_GROUP_ADDRESS_B, 14'd9999);
        set_register(REG_GROUP_ADDRESS_C, 14'd9999);
        send_header(hdr(20, 9999, 1, 1));
        send_header(hdr(21, 0, 1, 1));
        wait_for_results();
    endtask

    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rx_hold_left   = 300;
        repeat (8) send_header(random_header());
        // Hold the sender until every outstanding result has drained.
        wait_for_results();
        repeat (4) send_header(random_header());
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
        set_register(REG_OWN_ADDRESS, random_address());
        set_register(REG_GROUP_ADDRESS_A, random_address());
        set_register(REG_GROUP_ADDRESS_B, random_address());
        set_register(REG_GROUP_ADDRESS_C, random_address());
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) send_header(random_header());
        wait_for_results();
    endtask

    initial begin
        clear_model();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_addresses();
        test_address_registers();
        test_output_backpressure();
        test_random_traffic(180, 0, 0);
        test_random_traffic(180, 58, 0);
        test_random_traffic(180, 0, 58);
        test_random_traffic(180, 31, 31);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_verdicts.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_verdicts.size()));
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
